>>> rtl/tpbs_pkg.sv
package tpbs_pkg;

    localparam int ROWS_DEF = 16;
    localparam int COLS_DEF = 256;

    localparam int KIND_W = 3;
    localparam int ROW_W  = 4;
    localparam int COL_W  = 8;

    localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SWAP_IN = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SWAP_X  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TAIL    = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ROW_W-1:0]  row_a;
        logic [ROW_W-1:0]  row_b;
        logic [COL_W-1:0]  col_a;
        logic [COL_W-1:0]  col_b;
        logic              bit_value;
    } t_req;

    typedef struct packed {
        logic read_bit;
        logic swapped;
        logic status;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_B,
        S_EVAL,
        S_WR_B
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_a;
        logic rd_b;
        logic eval;
        logic wr_b;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic need_wb;
    } t_sts;

endpackage

>>> rtl/transition_preserving_bit_swap.sv
// Transition-preserving bit swap engine.
// Holds ROWS chains of COLS bits in a single-port row memory.
// Request channel: i_req is taken at a rising edge where start is high
// and busy is low. Kinds: write bit, read bit, within-row swap,
// cross-row swap, tail swap. A swap is done only if it keeps the
// number of 0/1 transitions of the chains unchanged.
// Result channel: o_valid is high for exactly one cycle with o_rsp;
// the receiver cannot stall, so the result must be taken then.
// Sequence: row A is read as the request is taken, then row B is read;
// S_EVAL writes row A back for a write or a swap, and for a swap S_WR_B
// writes row B. o_valid is registered from the last of these states.
// busy is high from acceptance through the last state, so a new request
// is taken only once the last one is done. The one memory port sets the order.
// Reset clears the controller and the result strobe. Memory contents
// are undefined until written and must be loaded with write requests.
module transition_preserving_bit_swap #(
    parameter int ROWS = tpbs_pkg::ROWS_DEF,
    parameter int COLS = tpbs_pkg::COLS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  tpbs_pkg::t_req i_req,
    output logic           o_valid,
    output tpbs_pkg::t_rsp o_rsp
);
    import tpbs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tpbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    tpbs_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

>>> rtl/tpbs_ctrl.sv
module tpbs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  tpbs_pkg::t_sts i_sts,
    output tpbs_pkg::t_cmd o_cmd,
    output logic           o_busy
);
    import tpbs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RD_B;
                end
            end
            S_RD_B: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = i_sts.need_wb ? S_WR_B : S_IDLE;
            end
            S_WR_B: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
                o_cmd.rd_a = i_start;
            end
            S_RD_B: begin
                o_cmd.rd_b = 1'b1;
            end
            S_EVAL: begin
                o_cmd.eval   = 1'b1;
                o_cmd.finish = !i_sts.need_wb;
            end
            S_WR_B: begin
                o_cmd.wr_b   = 1'b1;
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == S_IDLE)
        else $error("request finished but controller not idle");

    a_rd_then_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD_B |=> r_state == S_EVAL)
        else $error("second row read not followed by evaluation");

    a_load_then_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_RD_B && o_busy))
        else $error("accepted request did not start row reads");

endmodule

>>> rtl/tpbs_dp.sv
module tpbs_dp #(
    parameter int ROWS = tpbs_pkg::ROWS_DEF,
    parameter int COLS = tpbs_pkg::COLS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tpbs_pkg::t_cmd i_cmd,
    input  tpbs_pkg::t_req i_req,
    output tpbs_pkg::t_sts o_sts,
    output logic           o_valid,
    output tpbs_pkg::t_rsp o_rsp
);
    import tpbs_pkg::*;

    localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW  = $clog2(COLS);
    localparam logic [CW-1:0] TAIL_COL = CW'(COLS - 1);

    logic [COLS-1:0] mem [ROWS];

    logic [KIND_W-1:0] r_kind;
    logic [RAW-1:0]    r_ra;
    logic [RAW-1:0]    r_rb;
    logic              r_rows_ok;
    logic [CW-1:0]     r_ca;
    logic [CW-1:0]     r_cb;
    logic              r_col_ok;
    logic              r_bad_col;
    logic              r_same;
    logic              r_adj;
    logic              r_a_lt;
    logic              r_bv;
    logic [COLS-1:0]   r_row_a;
    logic [COLS-1:0]   r_q;
    logic [COLS-1:0]   r_new_b;
    t_rsp              r_rsp;
    logic              r_valid;

    logic [31:0] ra32, rb32, ca32, cb32;
    logic        ra_ok, rb_ok, a_inner, b_inner;
    logic        k_swap_in, k_swap_x, k_tail;

    always_comb begin
        ra32      = 32'(i_req.row_a);
        rb32      = 32'(i_req.row_b);
        ca32      = 32'(i_req.col_a);
        cb32      = 32'(i_req.col_b);
        ra_ok     = ra32 < 32'(ROWS);
        rb_ok     = rb32 < 32'(ROWS);
        a_inner   = (ca32 >= 32'd1) && (ca32 <= 32'(COLS - 2));
        b_inner   = (cb32 >= 32'd1) && (cb32 <= 32'(COLS - 2));
        k_swap_in = i_req.kind == KIND_SWAP_IN;
        k_swap_x  = i_req.kind == KIND_SWAP_X;
        k_tail    = i_req.kind == KIND_TAIL;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_req.kind;
            r_ra      <= ra32[RAW-1:0];
            r_rb      <= k_swap_in ? ra32[RAW-1:0] : rb32[RAW-1:0];
            r_rows_ok <= ra_ok && ((k_swap_x || k_tail) ? rb_ok : 1'b1);
            r_ca      <= k_tail ? TAIL_COL : ca32[CW-1:0];
            r_cb      <= k_tail ? TAIL_COL : cb32[CW-1:0];
            r_col_ok  <= ca32 < 32'(COLS);
            r_bad_col <= (k_swap_in || k_swap_x) && !(a_inner && b_inner);
            r_same    <= ca32 == cb32;
            r_adj     <= (ca32 + 32'd1 == cb32) || (cb32 + 32'd1 == ca32);
            r_a_lt    <= ca32 < cb32;
            r_bv      <= i_req.bit_value;
        end
    end

    function automatic logic pick(input logic [COLS-1:0] v, input logic [CW-1:0] idx);
        return (32'(idx) < 32'(COLS)) ? v[idx] : 1'b0;
    endfunction

    logic [CW-1:0] ca_m, ca_p, cb_m, cb_p;
    logic          a_x, b_y, a_l, a_r, b_l, b_r;
    logic          cond, do_swap, wa_ok, same_row;
    logic [1:0]    sum_a, sum_b;
    logic [COLS-1:0] new_a, new_b;

    always_comb begin
        ca_m  = r_ca - CW'(1);
        ca_p  = r_ca + CW'(1);
        cb_m  = r_cb - CW'(1);
        cb_p  = r_cb + CW'(1);
        a_x   = pick(r_row_a, r_ca);
        b_y   = pick(r_q, r_cb);
        a_l   = pick(r_row_a, ca_m);
        a_r   = pick(r_row_a, ca_p);
        b_l   = pick(r_q, cb_m);
        b_r   = pick(r_q, cb_p);
        sum_a = {1'b0, a_l} + {1'b0, a_r};
        sum_b = {1'b0, b_l} + {1'b0, b_r};
        case (r_kind)
            KIND_SWAP_IN: begin
                if (r_same) begin
                    cond = 1'b0;
                end else if (r_adj) begin
                    cond = r_a_lt ? (a_l == b_r) : (b_l == a_r);
                end else begin
                    cond = sum_a == sum_b;
                end
            end
            KIND_SWAP_X: begin
                cond = sum_a == sum_b;
            end
            KIND_TAIL: begin
                cond = a_l == b_l;
            end
            default: begin
                cond = 1'b0;
            end
        endcase
        do_swap  = cond && r_rows_ok && !r_bad_col;
        wa_ok    = (r_kind == KIND_WRITE) && r_rows_ok && r_col_ok;
        same_row = r_ra == r_rb;
        new_a    = r_row_a;
        new_b    = r_q;
        if (wa_ok) begin
            new_a[r_ca] = r_bv;
        end
        if (do_swap) begin
            new_a[r_ca] = b_y;
            new_b[r_cb] = a_x;
            if (same_row) begin
                new_a[r_cb] = a_x;
                new_b[r_ca] = b_y;
            end
        end
    end

    logic [RAW-1:0]  mem_addr;
    logic            mem_we;
    logic [COLS-1:0] mem_wd;

    always_comb begin
        mem_addr = r_ra;
        mem_we   = 1'b0;
        mem_wd   = new_a;
        if (i_cmd.rd_a) begin
            mem_addr = ra32[RAW-1:0];
        end else if (i_cmd.rd_b) begin
            mem_addr = r_rb;
        end else if (i_cmd.eval) begin
            mem_addr = r_ra;
            mem_we   = wa_ok || do_swap;
            mem_wd   = new_a;
        end else if (i_cmd.wr_b) begin
            mem_addr = r_rb;
            mem_we   = 1'b1;
            mem_wd   = r_new_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wd;
        end
        if (i_cmd.rd_a || i_cmd.rd_b) begin
            r_q <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_b) begin
            r_row_a <= r_q;
        end
        if (i_cmd.eval) begin
            r_new_b        <= new_b;
            r_rsp.read_bit <= (r_kind == KIND_READ) && r_rows_ok && r_col_ok && a_x;
            r_rsp.swapped  <= do_swap;
            r_rsp.status   <= r_bad_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    assign o_sts.need_wb = i_cmd.eval && do_swap;
    assign o_valid       = r_valid;
    assign o_rsp         = r_rsp;

    a_swap_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(r_rsp.swapped && r_rsp.status))
        else $error("swap reported together with bad column status");

    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(r_rsp.read_bit && (r_rsp.swapped || r_rsp.status)))
        else $error("read bit set on a swap result");

endmodule
